/* hdl/rtmc_pkg.sv */
// ----------------------------------------------------------------------------
// rtmc_pkg
// Shared constants and types of the rotated template match counter.
// ----------------------------------------------------------------------------
`default_nettype none

package rtmc_pkg;

	localparam int MAX_GRID_SIDE_DEF     = 64;
	localparam int MAX_TEMPLATE_SIDE_DEF = 16;

	localparam int CELL_W     = 8;
	localparam int TURNS_W    = 2;
	localparam int COUNT_W    = 13;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Input item kinds.
	localparam logic KIND_GRID     = 1'b0;
	localparam logic KIND_TEMPLATE = 1'b1;

	// Register select, taken from paddr bit 2.
	localparam logic REG_GRID_SIDE     = 1'b0;
	localparam logic REG_TEMPLATE_SIDE = 1'b1;

	localparam logic [TURNS_W-1:0] LAST_TURN = 2'd3;

	typedef struct packed {
		logic [TURNS_W-1:0] quarter_turns;
		logic [COUNT_W-1:0] match_count;
		logic               last_of_run;
	} result_t;

	typedef struct packed {
		logic    load;
		result_t res;
	} emit_t;

endpackage

`default_nettype wire

/* hdl/rtmc_in_if.sv */
// ----------------------------------------------------------------------------
// rtmc_in_if
// Cell input channel: valid/ready handshake with kind and cell value.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtmc_in_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [rtmc_pkg::CELL_W-1:0]    cell_value;

	modport source (output valid, output kind, output cell_value, input ready);
	modport sink (input valid, input kind, input cell_value, output ready);
endinterface

`default_nettype wire

/* hdl/rtmc_out_if.sv */
// ----------------------------------------------------------------------------
// rtmc_out_if
// Result output channel: valid/ready handshake with one match count.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtmc_out_if;
	logic                             valid;
	logic                             ready;
	logic [rtmc_pkg::TURNS_W-1:0]     quarter_turns;
	logic [rtmc_pkg::COUNT_W-1:0]     match_count;
	logic                             last_of_run;

	modport source (output valid, output quarter_turns, output match_count,
		output last_of_run, input ready);
	modport sink (input valid, input quarter_turns, input match_count,
		input last_of_run, output ready);
endinterface

`default_nettype wire

/* hdl/rtmc_search.sv */
// ----------------------------------------------------------------------------
// rtmc_search
// Search sequencer: walks every window position for each of the four
// rotations with one shared cell comparator and counts exact matches.
// ----------------------------------------------------------------------------
`default_nettype none

module rtmc_search #(
	parameter int MAX_GRID_SIDE     = rtmc_pkg::MAX_GRID_SIDE_DEF,
	parameter int MAX_TEMPLATE_SIDE = rtmc_pkg::MAX_TEMPLATE_SIDE_DEF,
	localparam int GW = $clog2(MAX_GRID_SIDE + 1),
	localparam int TW = $clog2(MAX_TEMPLATE_SIDE + 1),
	localparam int GA = $clog2(MAX_GRID_SIDE * MAX_GRID_SIDE),
	localparam int TA = (MAX_TEMPLATE_SIDE > 1) ?
		$clog2(MAX_TEMPLATE_SIDE * MAX_TEMPLATE_SIDE) : 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          out_free,
	input  wire logic [GW-1:0]                 grid_side,
	input  wire logic [TW-1:0]                 template_side,
	input  wire logic [rtmc_pkg::CELL_W-1:0]   grid_rdata,
	input  wire logic [rtmc_pkg::CELL_W-1:0]   tmpl_rdata,
	output logic      [GA-1:0]                 grid_raddr,
	output logic      [TA-1:0]                 tmpl_raddr,
	output logic                               busy,
	output rtmc_pkg::emit_t                    emit
);

	localparam int WX = (GW > TW) ? GW : TW;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]                     state_q;
	logic [rtmc_pkg::TURNS_W-1:0]   turns_q;
	logic [rtmc_pkg::COUNT_W-1:0]   count_q;
	logic [GW-1:0]                  row_q;
	logic [GW-1:0]                  col_q;
	logic [TW-1:0]                  x_q;
	logic [TW-1:0]                  y_q;
	logic [GA-1:0]                  base_q;
	logic [GA-1:0]                  rowoff_q;
	logic                           valid_s1;
	logic                           last_s1;

	logic                           too_big;
	logic [GW-1:0]                  span_m1;
	logic [TW-1:0]                  nm1;
	logic                           cell_last;
	logic                           mismatch;
	logic                           flush;
	logic [TW-1:0]                  src_row;
	logic [TW-1:0]                  src_col;
	logic [2*TW-1:0]                src_prod;

	assign too_big   = WX'(template_side) > WX'(grid_side);
	assign span_m1   = GW'(WX'(grid_side) - WX'(template_side));
	assign nm1       = template_side - TW'(1);
	assign cell_last = (x_q == nm1) && (y_q == nm1);
	assign mismatch  = grid_rdata != tmpl_rdata;
	assign flush     = valid_s1 && (mismatch || last_s1);

	// Rotation is done by addressing: map the window cell back to the stored one.
	always_comb begin
		case (turns_q)
			2'd0: begin
				src_row = x_q;
				src_col = y_q;
			end
			2'd1: begin
				src_row = nm1 - y_q;
				src_col = x_q;
			end
			2'd2: begin
				src_row = nm1 - x_q;
				src_col = nm1 - y_q;
			end
			default: begin
				src_row = y_q;
				src_col = nm1 - x_q;
			end
		endcase
		src_prod = src_row * template_side;
	end

	assign tmpl_raddr = TA'(src_prod + (2*TW)'(src_col));
	assign grid_raddr = base_q + rowoff_q + GA'(y_q);

	assign busy                  = state_q != ST_IDLE;
	assign emit.load             = (state_q == ST_EMIT) && out_free;
	assign emit.res.quarter_turns = turns_q;
	assign emit.res.match_count  = count_q;
	assign emit.res.last_of_run  = turns_q == rtmc_pkg::LAST_TURN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			turns_q  <= '0;
			count_q  <= '0;
			row_q    <= '0;
			col_q    <= '0;
			x_q      <= '0;
			y_q      <= '0;
			base_q   <= '0;
			rowoff_q <= '0;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						turns_q  <= '0;
						count_q  <= '0;
						row_q    <= '0;
						col_q    <= '0;
						x_q      <= '0;
						y_q      <= '0;
						base_q   <= '0;
						rowoff_q <= '0;
						valid_s1 <= 1'b0;
						state_q  <= too_big ? ST_EMIT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (flush) begin
						// The window is decided: either a cell differed or all matched.
						valid_s1 <= 1'b0;
						x_q      <= '0;
						y_q      <= '0;
						rowoff_q <= '0;
						if (!mismatch) begin
							count_q <= count_q + 1'b1;
						end
						if ((row_q == span_m1) && (col_q == span_m1)) begin
							state_q <= ST_EMIT;
						end else if (col_q == span_m1) begin
							col_q  <= '0;
							row_q  <= row_q + 1'b1;
							base_q <= base_q + GA'(template_side);
						end else begin
							col_q  <= col_q + 1'b1;
							base_q <= base_q + 1'b1;
						end
					end else begin
						valid_s1 <= 1'b1;
						last_s1  <= cell_last;
						if (!cell_last) begin
							if (y_q == nm1) begin
								y_q      <= '0;
								x_q      <= x_q + 1'b1;
								rowoff_q <= rowoff_q + GA'(grid_side);
							end else begin
								y_q <= y_q + 1'b1;
							end
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (turns_q == rtmc_pkg::LAST_TURN) begin
							state_q <= ST_IDLE;
						end else begin
							turns_q  <= turns_q + 1'b1;
							count_q  <= '0;
							row_q    <= '0;
							col_q    <= '0;
							x_q      <= '0;
							y_q      <= '0;
							base_q   <= '0;
							rowoff_q <= '0;
							valid_s1 <= 1'b0;
							state_q  <= too_big ? ST_EMIT : ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/rotated_template_match_counter.sv */
// A grid cell or a non-final template cell is written to its store when it is accepted.
// The final template cell starts a search of four rotations; each rotation scans
// span*span window positions (span = grid_side-template_side+1, no scan when the
// template is larger than the grid), then waits until the output register is free.
// Input is not ready during the search; one comparator, one read port.
// Reset clears sides to 1 and fill counts; stores keep data.
// ----------------------------------------------------------------------------
// rotated_template_match_counter
// Loads a grid and a template cell by cell and counts exact template matches
// under four clockwise quarter turns.
// ----------------------------------------------------------------------------
`default_nettype none

module rotated_template_match_counter #(
	parameter int MAX_GRID_SIDE     = rtmc_pkg::MAX_GRID_SIDE_DEF,
	parameter int MAX_TEMPLATE_SIDE = rtmc_pkg::MAX_TEMPLATE_SIDE_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [rtmc_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [rtmc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [rtmc_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                    pready,
	rtmc_in_if.sink                                 cell_in,
	rtmc_out_if.source                              count_out
);

	localparam int GW  = $clog2(MAX_GRID_SIDE + 1);
	localparam int TW  = $clog2(MAX_TEMPLATE_SIDE + 1);
	localparam int GA  = $clog2(MAX_GRID_SIDE * MAX_GRID_SIDE);
	localparam int TA  = (MAX_TEMPLATE_SIDE > 1) ?
		$clog2(MAX_TEMPLATE_SIDE * MAX_TEMPLATE_SIDE) : 1;
	localparam int GRID_CELLS = MAX_GRID_SIDE * MAX_GRID_SIDE;
	localparam int TMPL_CELLS = MAX_TEMPLATE_SIDE * MAX_TEMPLATE_SIDE;

	logic [GW-1:0]    gside_q;
	logic [TW-1:0]    tside_q;
	logic [GA:0]      gtotal_q;
	logic [TA:0]      ttotal_q;
	logic [GA-1:0]    gfill_q;
	logic [TA-1:0]    tfill_q;

	logic [rtmc_pkg::CELL_W-1:0] grid_mem [GRID_CELLS];
	logic [rtmc_pkg::CELL_W-1:0] tmpl_mem [TMPL_CELLS];
	logic [rtmc_pkg::CELL_W-1:0] grid_rdata_q;
	logic [rtmc_pkg::CELL_W-1:0] tmpl_rdata_q;

	logic                 out_valid_q;
	rtmc_pkg::result_t    out_res_q;

	logic                 cfg_wr;
	logic [6:0]           gval;
	logic [4:0]           tval;
	logic [GW-1:0]        gside_d;
	logic [TW-1:0]        tside_d;
	logic [2*GW-1:0]      gsq;
	logic [2*TW-1:0]      tsq;

	logic                 in_acc;
	logic                 grid_we;
	logic                 tmpl_we;
	logic                 grid_wrap;
	logic                 tmpl_last;
	logic                 start;
	logic                 out_free;
	logic                 busy;
	logic [GA-1:0]        grid_raddr;
	logic [TA-1:0]        tmpl_raddr;
	rtmc_pkg::emit_t      emit;

	// Configuration: sides come from pwdata[6:0] and pwdata[4:0]; 0 becomes 1, above MAX is clamped to MAX.
	assign cfg_wr = psel && penable && pwrite && pready;
	assign gval   = pwdata[6:0];
	assign tval   = pwdata[4:0];
	assign pready = 1'b1;
	assign prdata = (paddr[2] == rtmc_pkg::REG_TEMPLATE_SIDE) ?
		rtmc_pkg::APB_DATA_W'(tside_q) : rtmc_pkg::APB_DATA_W'(gside_q);

	always_comb begin
		if (gval == 7'd0) begin
			gside_d = GW'(1);
		end else if (gval > MAX_GRID_SIDE) begin
			gside_d = GW'(MAX_GRID_SIDE);
		end else begin
			gside_d = GW'(gval);
		end
		if (tval == 5'd0) begin
			tside_d = TW'(1);
		end else if (tval > MAX_TEMPLATE_SIDE) begin
			tside_d = TW'(MAX_TEMPLATE_SIDE);
		end else begin
			tside_d = TW'(tval);
		end
		gsq = gside_d * gside_d;
		tsq = tside_d * tside_d;
	end

	assign in_acc    = cell_in.valid && cell_in.ready;
	assign grid_we   = in_acc && (cell_in.kind == rtmc_pkg::KIND_GRID);
	assign tmpl_we   = in_acc && (cell_in.kind == rtmc_pkg::KIND_TEMPLATE);
	assign grid_wrap = ((GA+1)'(gfill_q) + 1'b1) == gtotal_q;
	assign tmpl_last = ((TA+1)'(tfill_q) + 1'b1) == ttotal_q;
	assign start     = tmpl_we && tmpl_last;
	assign cell_in.ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gside_q  <= GW'(1);
			tside_q  <= TW'(1);
			gtotal_q <= (GA+1)'(1);
			ttotal_q <= (TA+1)'(1);
			gfill_q  <= '0;
			tfill_q  <= '0;
		end else begin
			if (cfg_wr && (paddr[2] == rtmc_pkg::REG_GRID_SIDE)) begin
				gside_q  <= gside_d;
				gtotal_q <= (GA+1)'(gsq);
				gfill_q  <= '0;
			end else if (grid_we) begin
				gfill_q <= grid_wrap ? '0 : gfill_q + 1'b1;
			end
			if (cfg_wr && (paddr[2] == rtmc_pkg::REG_TEMPLATE_SIDE)) begin
				tside_q  <= tside_d;
				ttotal_q <= (TA+1)'(tsq);
				tfill_q  <= '0;
			end else if (tmpl_we) begin
				tfill_q <= tmpl_last ? '0 : tfill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (grid_we) begin
			grid_mem[gfill_q] <= cell_in.cell_value;
		end
		grid_rdata_q <= grid_mem[grid_raddr];
	end

	always_ff @(posedge clk) begin
		if (tmpl_we) begin
			tmpl_mem[tfill_q] <= cell_in.cell_value;
		end
		tmpl_rdata_q <= tmpl_mem[tmpl_raddr];
	end

	rtmc_search #(
		.MAX_GRID_SIDE     (MAX_GRID_SIDE),
		.MAX_TEMPLATE_SIDE (MAX_TEMPLATE_SIDE)
	) u_search (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.out_free      (out_free),
		.grid_side     (gside_q),
		.template_side (tside_q),
		.grid_rdata    (grid_rdata_q),
		.tmpl_rdata    (tmpl_rdata_q),
		.grid_raddr    (grid_raddr),
		.tmpl_raddr    (tmpl_raddr),
		.busy          (busy),
		.emit          (emit)
	);

	// One-entry output register; it can take a new result as the old one leaves.
	assign out_free = !out_valid_q || count_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.load) begin
			out_valid_q <= 1'b1;
		end else if (count_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			out_res_q <= emit.res;
		end
	end

	assign count_out.valid         = out_valid_q;
	assign count_out.quarter_turns = out_res_q.quarter_turns;
	assign count_out.match_count   = out_res_q.match_count;
	assign count_out.last_of_run   = out_res_q.last_of_run;

endmodule

`default_nettype wire

/* tb/rotated_template_match_counter_tb.sv */
// ----------------------------------------------------------------------------
// rotated_template_match_counter_tb
// Streams grids and templates into the match counter, predicts the four
// rotated match counts of every finished template, and compares each count
// transaction field by field. A short scripted sequence comes first, then
// randomized settings with planted and near-miss templates.
// ----------------------------------------------------------------------------

module rotated_template_match_counter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rtmc_pkg::*;

	localparam int GRID_CELLS    = MAX_GRID_SIDE_DEF * MAX_GRID_SIDE_DEF;
	localparam int TMPL_CELLS    = MAX_TEMPLATE_SIDE_DEF * MAX_TEMPLATE_SIDE_DEF;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_CELLS  = 160;

	typedef enum logic {ROW_CELL, ROW_WRITE} row_op_e;
	// Index q holds the count for q clockwise quarter turns.
	typedef logic [3:0][COUNT_W-1:0] four_counts_t;
	typedef struct packed {
		row_op_e               op;
		logic                  sel;
		logic [APB_DATA_W-1:0] value;
		logic                  typed;
		four_counts_t          counts;
	} step_row_t;

	localparam four_counts_t ONE_EACH = {4{13'd1}};

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	rtmc_in_if  cell_in ();
	rtmc_out_if count_out ();

	rotated_template_match_counter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cell_in   (cell_in),
		.count_out (count_out)
	);

	// Mirror of the block's stores, sides and fill positions.
	logic [CELL_W-1:0] grid_mem [GRID_CELLS];
	logic [CELL_W-1:0] tmpl_mem [TMPL_CELLS];
	int unsigned g_side = 1;
	int unsigned t_side = 1;
	int unsigned g_fill = 0;
	int unsigned t_fill = 0;

	result_t pending_counts [$];
	int errors = 0;
	int cells_sent = 0;
	int searches = 0;
	int counts_checked = 0;
	int reg_writes = 0;
	bit no_gaps = 0;

	// Counts for template side 1 and 2, both kinds of cell, the template
	// larger than the grid, and a template that only matches turned around.
	step_row_t script [25] = '{
		'{ROW_CELL,  KIND_GRID,         32'h00,        1'b0, '0},
		'{ROW_CELL,  KIND_TEMPLATE,     32'h00,        1'b1, ONE_EACH},
		'{ROW_CELL,  KIND_TEMPLATE,     32'hFF,        1'b1, '0},
		'{ROW_CELL,  KIND_GRID,         32'hFF,        1'b0, '0},
		'{ROW_CELL,  KIND_TEMPLATE,     32'hFF,        1'b1, ONE_EACH},
		'{ROW_WRITE, REG_TEMPLATE_SIDE, 32'h0000_0000, 1'b0, '0},
		'{ROW_CELL,  KIND_TEMPLATE,     32'hFF,        1'b1, ONE_EACH},
		'{ROW_WRITE, REG_TEMPLATE_SIDE, 32'h0000_0002, 1'b0, '0},
		'{ROW_CELL,  KIND_TEMPLATE,     32'h80,        1'b0, '0},
		'{ROW_CELL,  KIND_TEMPLATE,     32'h01,        1'b0, '0},
		'{ROW_CELL,  KIND_TEMPLATE,     32'h7F,        1'b0, '0},
		'{ROW_CELL,  KIND_TEMPLATE,     32'hFE,        1'b1, '0},
		'{ROW_WRITE, REG_GRID_SIDE,     32'hFFFF_FF82, 1'b0, '0},
		'{ROW_CELL,  KIND_GRID,         32'h01,        1'b0, '0},
		'{ROW_CELL,  KIND_GRID,         32'h02,        1'b0, '0},
		'{ROW_CELL,  KIND_GRID,         32'h03,        1'b0, '0},
		'{ROW_CELL,  KIND_GRID,         32'h04,        1'b0, '0},
		'{ROW_CELL,  KIND_TEMPLATE,     32'h01,        1'b0, '0},
		'{ROW_CELL,  KIND_TEMPLATE,     32'h02,        1'b0, '0},
		'{ROW_CELL,  KIND_TEMPLATE,     32'h03,        1'b0, '0},
		'{ROW_CELL,  KIND_TEMPLATE,     32'h04,        1'b1, {13'd0, 13'd0, 13'd0, 13'd1}},
		'{ROW_CELL,  KIND_TEMPLATE,     32'h03,        1'b0, '0},
		'{ROW_CELL,  KIND_TEMPLATE,     32'h01,        1'b0, '0},
		'{ROW_CELL,  KIND_TEMPLATE,     32'h04,        1'b0, '0},
		'{ROW_CELL,  KIND_TEMPLATE,     32'h02,        1'b1, {13'd1, 13'd0, 13'd0, 13'd0}}
	};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("FAIL rotated_template_match_counter");
		$finish;
	end

	// Template store index seen at (x, y) after the given clockwise turns.
	function automatic int unsigned turned_index(int unsigned turns, int unsigned x,
			int unsigned y, int unsigned n);
		int unsigned sr;
		int unsigned sc;
		case (turns)
			0: begin
				sr = x;
				sc = y;
			end
			1: begin
				sr = n - 1 - y;
				sc = x;
			end
			2: begin
				sr = n - 1 - x;
				sc = n - 1 - y;
			end
			default: begin
				sr = y;
				sc = n - 1 - x;
			end
		endcase
		return sr * n + sc;
	endfunction

	function automatic logic [COUNT_W-1:0] count_hits(int unsigned turns);
		int unsigned span;
		int unsigned hits = 0;
		bit same;
		if (t_side > g_side)
			return '0;
		span = g_side - t_side + 1;
		for (int unsigned r = 0; r < span; r++) begin
			for (int unsigned c = 0; c < span; c++) begin
				same = 1'b1;
				for (int unsigned x = 0; x < t_side && same; x++) begin
					for (int unsigned y = 0; y < t_side && same; y++) begin
						if (grid_mem[(r + x) * g_side + c + y] !==
								tmpl_mem[turned_index(turns, x, y, t_side)])
							same = 1'b0;
					end
				end
				if (same)
					hits++;
			end
		end
		return hits[COUNT_W-1:0];
	endfunction

	function automatic logic [CELL_W-1:0] draw_symbol(bit narrow, logic [CELL_W-1:0] a,
			logic [CELL_W-1:0] b);
		if (narrow)
			return ($urandom_range(1) != 0) ? a : b;
		return CELL_W'($urandom);
	endfunction

	// Waits until every count has arrived and the block has gone quiet, then
	// writes one register and updates the mirrored side.
	task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] val);
		int unsigned side;
		cell_in.valid <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		reg_writes++;
		if (idx == REG_GRID_SIDE) begin
			side = val[6:0];
			g_side = (side == 0) ? 1 : (side > MAX_GRID_SIDE_DEF) ? MAX_GRID_SIDE_DEF : side;
			g_fill = 0;
		end else begin
			side = val[4:0];
			t_side = (side == 0) ? 1 :
				(side > MAX_TEMPLATE_SIDE_DEF) ? MAX_TEMPLATE_SIDE_DEF : side;
			t_fill = 0;
		end
	endtask

	// Offers one cell; once the transaction completes, stores it in the mirror
	// and queues the four counts when it finishes a template.
	task automatic send_cell(input logic kind, input logic [CELL_W-1:0] value,
			input logic typed, input four_counts_t counts);
		int unsigned total;
		bit done = 1'b0;
		result_t res;
		while (!no_gaps && $urandom_range(99) < 8) begin
			cell_in.valid <= 1'b0;
			@(posedge clk);
		end
		cell_in.valid      <= 1'b1;
		cell_in.kind       <= kind;
		cell_in.cell_value <= value;
		@(posedge clk);
		while (cell_in.ready !== 1'b1)
			@(posedge clk);
		cells_sent++;
		if (kind == KIND_GRID) begin
			total = g_side * g_side;
			if (g_fill >= total)
				g_fill = 0;
			grid_mem[g_fill] = value;
			g_fill++;
			if (g_fill >= total)
				g_fill = 0;
		end else begin
			total = t_side * t_side;
			if (t_fill >= total)
				t_fill = 0;
			tmpl_mem[t_fill] = value;
			t_fill++;
			if (t_fill >= total) begin
				t_fill = 0;
				done = 1'b1;
			end
		end
		if (done) begin
			searches++;
			for (int q = 0; q < 4; q++) begin
				res.quarter_turns = q[TURNS_W-1:0];
				res.match_count   = typed ? counts[q] : count_hits(q);
				res.last_of_run   = (res.quarter_turns == LAST_TURN);
				pending_counts.push_back(res);
			end
		end
	endtask

	// One setting: a full grid, then several searches. Most templates are cut
	// from the grid and turned, some with one cell spoiled; some searches are
	// preceded by stray grid cells or by an unfinished fill that a register
	// write throws away.
	task automatic run_phase(input logic [APB_DATA_W-1:0] g_raw,
			input logic [APB_DATA_W-1:0] t_raw, input int runs);
		logic [CELL_W-1:0] pattern [TMPL_CELLS];
		logic [CELL_W-1:0] sym_a;
		logic [CELL_W-1:0] sym_b;
		bit narrow;
		int unsigned span;
		int unsigned r;
		int unsigned c;
		int unsigned turns;
		int unsigned m;
		write_reg(REG_GRID_SIDE, g_raw);
		write_reg(REG_TEMPLATE_SIDE, t_raw);
		sym_a  = CELL_W'($urandom);
		sym_b  = CELL_W'($urandom);
		narrow = ($urandom_range(3) != 0);
		for (int unsigned i = 0; i < g_side * g_side; i++)
			send_cell(KIND_GRID, draw_symbol(narrow, sym_a, sym_b), 1'b0, '0);
		repeat (runs) begin
			if (g_side > 1 && $urandom_range(5) == 0) begin
				m = $urandom_range(g_side * g_side - 1, 1);
				repeat (m) send_cell(KIND_GRID, draw_symbol(narrow, sym_a, sym_b), 1'b0, '0);
				write_reg(REG_GRID_SIDE, g_raw);
			end else if ($urandom_range(3) == 0) begin
				m = $urandom_range(g_side * g_side, 1);
				repeat (m) send_cell(KIND_GRID, draw_symbol(narrow, sym_a, sym_b), 1'b0, '0);
			end
			if (t_side > 1 && $urandom_range(5) == 0) begin
				m = $urandom_range(t_side * t_side - 1, 1);
				repeat (m) send_cell(KIND_TEMPLATE, draw_symbol(narrow, sym_a, sym_b), 1'b0, '0);
				write_reg(REG_TEMPLATE_SIDE, t_raw);
			end
			if (t_side <= g_side && $urandom_range(3) != 0) begin
				span  = g_side - t_side + 1;
				r     = $urandom_range(span - 1);
				c     = $urandom_range(span - 1);
				turns = $urandom_range(3);
				for (int unsigned x = 0; x < t_side; x++)
					for (int unsigned y = 0; y < t_side; y++)
						pattern[turned_index(turns, x, y, t_side)] =
							grid_mem[(r + x) * g_side + c + y];
				if ($urandom_range(3) == 0)
					pattern[$urandom_range(t_side * t_side - 1)] ^= CELL_W'($urandom_range(255, 1));
			end else begin
				for (int unsigned i = 0; i < t_side * t_side; i++)
					pattern[i] = draw_symbol(narrow, sym_a, sym_b);
			end
			for (int unsigned i = 0; i < t_side * t_side; i++)
				send_cell(KIND_TEMPLATE, pattern[i], 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin : check_counts
		result_t want;
		if (count_out.valid === 1'b1 && count_out.ready === 1'b1) begin
			if (pending_counts.size() == 0) begin
				$error("unexpected count: quarter_turns %0d match_count %0d",
					count_out.quarter_turns, count_out.match_count);
				errors++;
			end else begin
				want = pending_counts.pop_front();
				counts_checked++;
				if (count_out.quarter_turns !== want.quarter_turns) begin
					$error("quarter_turns: expected %0d, got %0d",
						want.quarter_turns, count_out.quarter_turns);
					errors++;
				end
				if (count_out.match_count !== want.match_count) begin
					$error("match_count: expected %0d, got %0d",
						want.match_count, count_out.match_count);
					errors++;
				end
				if (count_out.last_of_run !== want.last_of_run) begin
					$error("last_of_run: expected %0d, got %0d",
						want.last_of_run, count_out.last_of_run);
					errors++;
				end
			end
		end
		count_out.ready <= no_gaps || ($urandom_range(99) >= 8);
	end

	initial begin : stimulus
		int start;
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		cell_in.valid      = 1'b0;
		cell_in.kind       = KIND_GRID;
		cell_in.cell_value = '0;
		count_out.ready    = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].op == ROW_WRITE)
				write_reg(script[i].sel, script[i].value);
			else
				send_cell(script[i].sel, script[i].value[CELL_W-1:0], script[i].typed,
					script[i].counts);
		end

		// A grid of side ten goes through with no random gaps in the cell stream or in count_out.ready.
		no_gaps = 1'b1;
		run_phase(32'h0000_000A, 32'h0000_0002, 2);
		no_gaps = 1'b0;
		run_phase(32'h0000_0006, 32'h0000_0001, 1);
		run_phase(32'hFFFF_FF85, 32'h0000_0003, 3);
		run_phase(32'h0000_0003, 32'hFFFF_FFE4, 2);
		run_phase(32'h0000_0080, 32'hFFFF_FFE0, 3);

		start = cells_sent;
		while (cells_sent - start < RANDOM_CELLS)
			run_phase(($urandom & ~32'h7F) | $urandom_range(8, 1),
				($urandom & ~32'h1F) | $urandom_range(3, 1), $urandom_range(4, 2));

		cell_in.valid <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Streamed %0d cells across %0d register writes, grid sides 1 to 10.",
			cells_sent, reg_writes);
		$display("Ran %0d searches and compared %0d rotated counts.", searches, counts_checked);
		if (errors == 0)
			$display("PASS rotated_template_match_counter");
		else
			$display("FAIL rotated_template_match_counter");
		$finish;
	end

endmodule
